@@ hdl/hem_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hem_pkg
// Shared types and constants for the histogram equalization map block.
// ----------------------------------------------------------------------------
package hem_pkg;

    // Width and reset value of the pixel total register
    localparam int unsigned TOTAL_BITS = 25;
    localparam logic [TOTAL_BITS-1:0] TOTAL_RESET = 25'd65536;

    // Output level and bin index widths
    localparam int unsigned LEVEL_BITS = 8;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 8'd255;
    localparam logic [LEVEL_BITS-1:0] LEVEL_ZERO = 8'd0;
    localparam int unsigned INDEX_BITS = 8;

    // Divider step counter: one quotient bit per step
    localparam int unsigned STEP_BITS = 3;
    localparam logic [STEP_BITS-1:0] STEP_FIRST = 3'd7;
    localparam logic [STEP_BITS-1:0] STEP_LAST = 3'd0;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SEND
    } hem_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;
        logic prep;
        logic step;
        logic load;
    } hem_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_last;
    } hem_status_t;

endpackage
`default_nettype wire

@@ hdl/hem_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hem_datapath
// Cumulative count, numerator and denominator set-up, restoring divider and
// output payload register of the histogram equalization map.
// ----------------------------------------------------------------------------
module hem_datapath #(
    parameter int unsigned COUNT_BITS = 25,
    parameter int unsigned BIN_COUNT  = 256,
    parameter int unsigned BIN_BITS   = 8
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire hem_pkg::hem_cmd_t                cmd,
    output hem_pkg::hem_status_t                  status,
    input  wire                                   cfg_we,
    input  wire [hem_pkg::TOTAL_BITS-1:0]         cfg_data,
    input  wire [COUNT_BITS-1:0]                  bin_count,
    output logic [hem_pkg::LEVEL_BITS-1:0]        mapped_level,
    output logic [hem_pkg::INDEX_BITS-1:0]        bin_index,
    output logic                                  last_bin,
    output logic                                  degenerate
);

    localparam int unsigned NUM_BITS = COUNT_BITS + hem_pkg::LEVEL_BITS;
    localparam logic [BIN_BITS-1:0] BIN_LAST = BIN_BITS'(BIN_COUNT - 1);
    localparam logic [BIN_BITS-1:0] BIN_ZERO = '0;

    // Control state
    logic [hem_pkg::TOTAL_BITS-1:0] pixel_total_reg;
    logic [BIN_BITS-1:0]            next_bin_reg;
    logic [BIN_BITS-1:0]            next_bin_next;
    logic [COUNT_BITS-1:0]          sum_reg;
    logic [COUNT_BITS-1:0]          sum_next;
    logic [COUNT_BITS-1:0]          first_reg;
    logic [COUNT_BITS-1:0]          first_next;

    // Per-word working registers
    logic [BIN_BITS-1:0]                 cur_bin_reg;
    logic                                cur_last_reg;
    logic                                degen_reg;
    logic                                sat_reg;
    logic [COUNT_BITS-1:0]               den_reg;
    logic [COUNT_BITS-1:0]               rem_reg;
    logic [COUNT_BITS-1:0]               rem_next;
    logic [hem_pkg::LEVEL_BITS-1:0]      low_reg;
    logic [hem_pkg::LEVEL_BITS-1:0]      quo_reg;
    logic [hem_pkg::STEP_BITS-1:0]       step_reg;

    // Combinational helpers
    logic                           is_first;
    logic                           is_last;
    logic [COUNT_BITS:0]            sum_wide;
    logic [COUNT_BITS-1:0]          total_w;
    logic [COUNT_BITS-1:0]          diff;
    logic [NUM_BITS-1:0]            num;
    logic [COUNT_BITS-1:0]          den;
    logic                           degen_w;
    logic                           sat_w;
    logic [COUNT_BITS:0]            trial;
    logic [COUNT_BITS:0]            trial_sub;
    logic                           fits;
    logic [hem_pkg::LEVEL_BITS-1:0] level;

    // Running sum with saturation; bin 0 restarts the table
    always_comb
    begin
        is_first = (next_bin_reg == BIN_ZERO);
        is_last  = (next_bin_reg == BIN_LAST);
        sum_wide = {1'b0, sum_reg} + {1'b0, bin_count};
        if (is_first)
        begin
            sum_next   = bin_count;
            first_next = bin_count;
        end
        else
        begin
            sum_next   = sum_wide[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum_wide[COUNT_BITS-1:0];
            first_next = first_reg;
        end
        next_bin_next = is_last ? BIN_ZERO : next_bin_reg + BIN_BITS'(1);
    end

    // Numerator (diff * 255) and denominator, degenerate and saturation tests
    always_comb
    begin
        total_w = COUNT_BITS'(pixel_total_reg);
        diff    = sum_reg - first_reg;
        num     = {diff, hem_pkg::LEVEL_BITS'(0)} - NUM_BITS'(diff);
        den     = total_w - first_reg;
        degen_w = (total_w <= first_reg);
        sat_w   = (num >= {den, hem_pkg::LEVEL_BITS'(0)});
    end

    // One restoring division step: shift in a numerator bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, low_reg[hem_pkg::LEVEL_BITS-1]};
        trial_sub = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        rem_next  = fits ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
    end

    // Final level selection
    always_comb
    begin
        if (degen_reg)
        begin
            level = hem_pkg::LEVEL_ZERO;
        end
        else if (sat_reg)
        begin
            level = hem_pkg::LEVEL_MAX;
        end
        else
        begin
            level = quo_reg;
        end
    end

    assign status.div_last = (step_reg == hem_pkg::STEP_LAST);

    // Control state: pixel total register, sums, bin counter and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_total_reg <= hem_pkg::TOTAL_RESET;
            next_bin_reg    <= '0;
            sum_reg         <= '0;
            first_reg       <= '0;
            step_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                pixel_total_reg <= cfg_data;
            end
            if (cmd.take)
            begin
                next_bin_reg <= next_bin_next;
                sum_reg      <= sum_next;
                first_reg    <= first_next;
            end
            if (cmd.prep)
            begin
                step_reg <= hem_pkg::STEP_FIRST;
            end
            else if (cmd.step)
            begin
                step_reg <= step_reg - hem_pkg::STEP_BITS'(1);
            end
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            cur_bin_reg  <= next_bin_reg;
            cur_last_reg <= is_last;
        end
        if (cmd.prep)
        begin
            rem_reg   <= num[NUM_BITS-1:hem_pkg::LEVEL_BITS];
            low_reg   <= num[hem_pkg::LEVEL_BITS-1:0];
            den_reg   <= den;
            degen_reg <= degen_w;
            sat_reg   <= sat_w;
            quo_reg   <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[hem_pkg::LEVEL_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[hem_pkg::LEVEL_BITS-2:0], fits};
        end
        if (cmd.load)
        begin
            mapped_level <= level;
            bin_index    <= hem_pkg::INDEX_BITS'(cur_bin_reg);
            last_bin     <= cur_last_reg;
            degenerate   <= degen_reg;
        end
    end

endmodule
`default_nettype wire

@@ hdl/hem_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hem_ctrl
// Sequencer for the histogram equalization map: takes a word, sets up the
// division, runs the divider steps and hands the result to the output slot.
// ----------------------------------------------------------------------------
module hem_ctrl (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire                       out_stall,
    output hem_pkg::hem_cmd_t         cmd,
    input  wire hem_pkg::hem_status_t status
);

    hem_pkg::hem_state_t state_reg;
    hem_pkg::hem_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hem_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hem_pkg::ST_PREP;
                end
            end
            hem_pkg::ST_PREP:
            begin
                state_next = hem_pkg::ST_DIV;
            end
            hem_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = hem_pkg::ST_SEND;
                end
            end
            hem_pkg::ST_SEND:
            begin
                if (slot_free)
                begin
                    state_next = hem_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hem_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            hem_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
            end
            hem_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            hem_pkg::ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            hem_pkg::ST_SEND:
            begin
                cmd.load = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Output slot: fill on load, drain when the receiver takes the word
    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hem_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/histogram_equalization_map_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_equalization_map_core
// Builds the equalization lookup table of one colour channel from its bin
// counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / bin_count): one histogram bin count
//   per word, bins in order 0 to BIN_COUNT-1; the bin counter wraps after the
//   last bin and the next word starts a new table.
//   Output channel (out_valid / out_stall / mapped_level, bin_index,
//   last_bin, degenerate): one word per input word, in the same order.
//   Configuration (cfg_valid / cfg_ready / cfg_data): pixel total of the
//   image; cfg_ready is always high. Write it between tables while idle.
//   Timing: a word accepted in the idle state passes through the set-up
//   state, the eight-step restoring divider and the hand-off state before it
//   reaches the output register; no new word is accepted until the block
//   has handed the last one over.
//   Reset clears the sums, the bin counter and the output slot, and loads
//   the pixel total with 65536.
//   While the receiver stalls, the output word holds; the block finishes the
//   next word and then waits to hand it over, stalling its input meanwhile.
// ----------------------------------------------------------------------------
module histogram_equalization_map_core #(
    parameter int unsigned BIN_COUNT  = 256,
    parameter int unsigned COUNT_BITS = 25
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire [COUNT_BITS-1:0]               bin_count,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [hem_pkg::LEVEL_BITS-1:0]     mapped_level,
    output logic [hem_pkg::INDEX_BITS-1:0]     bin_index,
    output logic                               last_bin,
    output logic                               degenerate,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [hem_pkg::TOTAL_BITS-1:0]      cfg_data
);

    localparam int unsigned BIN_BITS = $clog2(BIN_COUNT);

    hem_pkg::hem_cmd_t    cmd;
    hem_pkg::hem_status_t status;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    hem_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    hem_datapath #(
        .COUNT_BITS (COUNT_BITS),
        .BIN_COUNT  (BIN_COUNT),
        .BIN_BITS   (BIN_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .bin_count    (bin_count),
        .mapped_level (mapped_level),
        .bin_index    (bin_index),
        .last_bin     (last_bin),
        .degenerate   (degenerate)
    );

endmodule
`default_nettype wire

@@ hdl/hem_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hem_checker
// Port-level checks for the histogram equalization map, bound to the top.
// ----------------------------------------------------------------------------
module hem_checker #(
    parameter int unsigned BIN_COUNT = 256
) (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            in_valid,
    input wire                            in_stall,
    input wire                            out_valid,
    input wire                            out_stall,
    input wire [hem_pkg::LEVEL_BITS-1:0]  mapped_level,
    input wire [hem_pkg::INDEX_BITS-1:0]  bin_index,
    input wire                            last_bin,
    input wire                            degenerate
);

    localparam logic [hem_pkg::INDEX_BITS-1:0] INDEX_LAST =
        hem_pkg::INDEX_BITS'(BIN_COUNT - 1);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mapped_level)
            && $stable(bin_index) && $stable(last_bin) && $stable(degenerate))
        else $error("output word changed while stalled");

    // A degenerate table gives level zero
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> mapped_level == hem_pkg::LEVEL_ZERO)
        else $error("degenerate word with non-zero level");

    // The end-of-table flag marks the last bin index
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_bin |-> bin_index == INDEX_LAST)
        else $error("last_bin with wrong bin index");

    // One word at a time: the input is stalled right after an accept
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

endmodule

bind histogram_equalization_map_core hem_checker #(
    .BIN_COUNT (BIN_COUNT)
) u_hem_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mapped_level (mapped_level),
    .bin_index    (bin_index),
    .last_bin     (last_bin),
    .degenerate   (degenerate)
);
`default_nettype wire

@@ verif/tb_histogram_equalization_map_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_histogram_equalization_map_core
// Self-checking bench for the equalization table builder. A short table of
// hand-picked bin counts comes first: degenerate totals, overflowing sums and
// saturated levels. Random tables follow, with pixel totals changed between
// phases. A local predictor of the CDF mapping supplies every expected word.
// ----------------------------------------------------------------------------
module tb_histogram_equalization_map_core;

    localparam int CNT_BITS   = hem_pkg::TOTAL_BITS;
    localparam int BINS       = 256;
    localparam int ITEMS      = 950;
    localparam int PLAN_ROWS  = 12;
    localparam int QUIET_MAX  = 3000;
    localparam int HOLDOFF    = 200;
    localparam int TAIL       = 24;

    localparam logic [CNT_BITS-1:0] TOTAL_MIN  = 25'd1;
    localparam logic [CNT_BITS-1:0] TOTAL_MAX  = 25'd16777216;
    localparam logic [CNT_BITS-1:0] COUNT_ONES = '1;

    typedef enum logic [1:0] {
        SHAPE_SPREAD,
        SHAPE_WIDE,
        SHAPE_SPARSE
    } count_shape_t;

    typedef struct packed {
        logic [hem_pkg::LEVEL_BITS-1:0] level;
        logic [hem_pkg::INDEX_BITS-1:0] index;
        logic                           last;
        logic                           degen;
    } bin_map_t;

    typedef struct packed {
        logic                           write_total;
        logic [CNT_BITS-1:0]            total;
        logic [CNT_BITS-1:0]            count;
        logic                           typed;
        logic [hem_pkg::LEVEL_BITS-1:0] level;
        logic                           degen;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [CNT_BITS-1:0]            bin_count = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [hem_pkg::LEVEL_BITS-1:0] mapped_level;
    logic [hem_pkg::INDEX_BITS-1:0] bin_index;
    logic                           last_bin;
    logic                           degenerate;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [CNT_BITS-1:0]            cfg_data = '0;

    // Predictor state
    logic [CNT_BITS-1:0]            model_total = hem_pkg::TOTAL_RESET;
    logic [CNT_BITS-1:0]            cum_count = '0;
    logic [CNT_BITS-1:0]            first_count = '0;
    logic [hem_pkg::INDEX_BITS-1:0] bin_ptr = '0;

    bin_map_t level_q [$];

    int  failures = 0;
    int  words_in = 0;
    int  words_out = 0;
    int  quiet_cycles = 0;
    int  holdoff_left = 0;
    bit  holdoff_done = 1'b0;
    int  tables_done = 0;
    int  degen_seen = 0;
    int  sat_seen = 0;
    int  total_writes = 0;
    logic calm;

    // Directed table: reset total, degenerate totals, overflow, saturation
    plan_row_t plan [0:PLAN_ROWS-1] = '{
        '{1'b0, 25'd0,      25'd65536,    1'b1, hem_pkg::LEVEL_ZERO, 1'b1},
        '{1'b0, 25'd0,      25'd0,        1'b1, hem_pkg::LEVEL_ZERO, 1'b1},
        '{1'b1, TOTAL_MIN,  25'd12,       1'b1, hem_pkg::LEVEL_ZERO, 1'b1},
        '{1'b1, TOTAL_MAX,  25'd0,        1'b1, hem_pkg::LEVEL_ZERO, 1'b0},
        '{1'b0, 25'd0,      25'd1,        1'b0, hem_pkg::LEVEL_ZERO, 1'b0},
        '{1'b0, 25'd0,      25'd16711679, 1'b1, hem_pkg::LEVEL_MAX,  1'b0},
        '{1'b0, 25'd0,      25'd16777216, 1'b1, hem_pkg::LEVEL_MAX,  1'b0},
        '{1'b0, 25'd0,      COUNT_ONES,   1'b1, hem_pkg::LEVEL_MAX,  1'b0},
        '{1'b1, 25'd200000, 25'd0,        1'b0, hem_pkg::LEVEL_ZERO, 1'b0},
        '{1'b1, 25'd65536,  25'd777,      1'b1, hem_pkg::LEVEL_ZERO, 1'b1},
        '{1'b1, TOTAL_MAX,  25'd4095,     1'b0, hem_pkg::LEVEL_ZERO, 1'b0},
        '{1'b0, 25'd0,      25'd1,        1'b0, hem_pkg::LEVEL_ZERO, 1'b0}
    };

    histogram_equalization_map_core #(
        .BIN_COUNT  (BINS),
        .COUNT_BITS (CNT_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .bin_count    (bin_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mapped_level (mapped_level),
        .bin_index    (bin_index),
        .last_bin     (last_bin),
        .degenerate   (degenerate),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stretch with no random idling on either side
    assign calm = (words_in >= 500) && (words_in < 650);

    // Equalized level of the next bin; advances the running sums
    function automatic bin_map_t map_bin(input logic [CNT_BITS-1:0] cnt);
        logic [CNT_BITS:0] sum;
        logic [63:0]       quot;
        bin_map_t          r;
        if (bin_ptr == '0)
        begin
            first_count = cnt;
            cum_count   = cnt;
        end
        else
        begin
            sum       = {1'b0, cum_count} + {1'b0, cnt};
            cum_count = sum[CNT_BITS] ? COUNT_ONES : sum[CNT_BITS-1:0];
        end
        r.index = bin_ptr;
        r.last  = (bin_ptr == BINS - 1);
        if (model_total <= first_count)
        begin
            r.degen = 1'b1;
            r.level = hem_pkg::LEVEL_ZERO;
        end
        else
        begin
            quot    = (64'(cum_count - first_count) * 64'(hem_pkg::LEVEL_MAX))
                      / 64'(model_total - first_count);
            r.degen = 1'b0;
            r.level = (quot > 64'(hem_pkg::LEVEL_MAX)) ? hem_pkg::LEVEL_MAX
                                                       : quot[7:0];
        end
        bin_ptr = r.last ? '0 : bin_ptr + 1'b1;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch: expected %0d, got %0d",
                     $time, name, want, got);
            failures++;
        end
    endtask

    // Offer one word from a falling edge; return on the falling edge after
    // it is taken. A typed row overrides the predicted level and flag.
    task automatic send_word(input logic [CNT_BITS-1:0] cnt, input logic typed,
                             input logic [hem_pkg::LEVEL_BITS-1:0] lvl,
                             input logic dg);
        bin_map_t w;
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        bin_count <= cnt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        w = map_bin(cnt);
        if (typed)
        begin
            w.level = lvl;
            w.degen = dg;
        end
        level_q.push_back(w);
        @(negedge clk);
    endtask

    // Hold the input idle until every expected word has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (level_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_total(input logic [CNT_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_total = value;
        total_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, one long hold-off while the sender offers
    always @(negedge clk)
    begin
        if (holdoff_left != 0)
        begin
            out_stall    <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end
        else if (!holdoff_done && words_out >= 300 && in_valid)
        begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF - 1;
            out_stall    <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 16);
    end

    // Check each word taken from the output against the oldest expectation
    always @(posedge clk)
    begin : monitor
        bin_map_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                words_in++;
            if (out_valid && !out_stall)
            begin
                words_out++;
                if (level_q.size() == 0)
                begin
                    $display("%0t ns: unexpected word: expected none, got bin %0d level %0d",
                             $time, bin_index, mapped_level);
                    failures++;
                end
                else
                begin
                    want = level_q.pop_front();
                    check_field("mapped_level", want.level, mapped_level);
                    check_field("bin_index", want.index, bin_index);
                    check_field("last_bin", want.last, last_bin);
                    check_field("degenerate", want.degen, degenerate);
                    tables_done += want.last;
                    degen_seen  += want.degen;
                    sat_seen    += (want.level == hem_pkg::LEVEL_MAX);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        while (quiet_cycles < QUIET_MAX)
            @(posedge clk);
        $display("%0t ns: no word moved for %0d cycles", $time, QUIET_MAX);
        $display("histogram_equalization_map_core regression: fail");
        $finish;
    end

    initial
    begin
        int                  i;
        int                  sent;
        int                  phase_len;
        int                  avg;
        int unsigned         pick;
        count_shape_t        shape;
        logic [CNT_BITS-1:0] cnt;
        logic [CNT_BITS-1:0] tot;

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows
        for (i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].write_total)
            begin
                drain();
                write_total(plan[i].total);
            end
            send_word(plan[i].count, plan[i].typed, plan[i].level, plan[i].degen);
        end

        // Random phases: mostly rest-of-table runs, some cut mid-table
        sent = PLAN_ROWS;
        while (sent < ITEMS)
        begin
            drain();
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 9))
                    0: tot = TOTAL_MIN;
                    1: tot = TOTAL_MAX;
                    2: tot = CNT_BITS'($urandom_range(1, TOTAL_MAX));
                    3: tot = CNT_BITS'($urandom_range(1, 1000));
                    default: tot = CNT_BITS'($urandom_range(256, 300000));
                endcase
                write_total(tot);
            end
            phase_len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60)
                                                    : BINS - bin_ptr;
            if (phase_len > ITEMS - sent)
                phase_len = ITEMS - sent;
            pick  = $urandom_range(0, 9);
            shape = (pick < 7) ? SHAPE_SPREAD : (pick < 9) ? SHAPE_WIDE : SHAPE_SPARSE;
            avg   = model_total / BINS + 1;
            repeat (phase_len)
            begin
                case (shape)
                    SHAPE_WIDE:
                        cnt = CNT_BITS'($urandom);
                    SHAPE_SPARSE:
                        cnt = ($urandom_range(0, 7) == 0)
                              ? CNT_BITS'($urandom_range(0, model_total)) : '0;
                    default:
                        // bin 0 now and then at or above the total
                        if (bin_ptr == '0 && $urandom_range(0, 5) == 0)
                            cnt = model_total + CNT_BITS'($urandom_range(0, 100));
                        else
                            cnt = CNT_BITS'($urandom_range(0, 2 * avg));
                endcase
                send_word(cnt, 1'b0, hem_pkg::LEVEL_ZERO, 1'b0);
                sent++;
            end
        end

        // Let the last words out, then watch a quiet tail
        drain();
        repeat (TAIL) @(posedge clk);

        $display("Covered %0d bin words across %0d complete tables and %0d total writes;",
                 words_out, tables_done, total_writes);
        $display("%0d words were degenerate and %0d saturated at full level.",
                 degen_seen, sat_seen);
        if (failures == 0)
            $display("histogram_equalization_map_core regression: pass");
        else
            $display("histogram_equalization_map_core regression: fail");
        $finish;
    end

endmodule
